FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/htd_pkg.sv
`default_nettype none
package htd_pkg;

    localparam int MAX_NODES    = 512;
    localparam int MAX_CODE_LEN = 32;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NODE_CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CODE_LEN_W  = 6;
    localparam int CODE_BITS_W = 32;
    localparam int CODE_POS_W  = 5;
    localparam int SYM_W       = 8;
    localparam int COUNT_W     = 32;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_BIT   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    // One tree node; a child index of zero means no child.
    typedef struct packed {
        logic                   leaf;
        logic [SYM_W-1:0]       sym;
        logic [1:0][NODE_W-1:0] kid;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    typedef struct packed {
        logic             valid;
        logic             symbol_valid;
        logic [SYM_W-1:0] out_symbol;
        logic [1:0]       status;
        logic             done;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIT_WAIT,
        ST_LOAD_STEP,
        ST_LOAD_READ
    } state_t;

endpackage
`default_nettype wire

FILE: sv/htd_node_ram.sv
`default_nettype none
module htd_node_ram
    import htd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [NODE_W-1:0]    wr_addr,
    input  wire logic [NODE_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [NODE_W-1:0]    rd_addr,
    output logic      [NODE_BITS-1:0] rd_data
);

    logic [NODE_BITS-1:0] mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/htd_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module htd_ctrl
    import htd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [1:0]             req_type,
    input  wire logic [COUNT_W-1:0]     symbol_count,
    input  wire logic [SYM_W-1:0]       symbol,
    input  wire logic [CODE_LEN_W-1:0]  code_len,
    input  wire logic [CODE_BITS_W-1:0] code_bits,
    input  wire logic                   bit_req,
    output logic                        busy,
    output res_t                        res,
    output logic                        ram_wr_en,
    output logic [NODE_W-1:0]           ram_wr_addr,
    output logic [NODE_BITS-1:0]        ram_wr_data,
    output logic                        ram_rd_en,
    output logic [NODE_W-1:0]           ram_rd_addr,
    input  wire logic [NODE_BITS-1:0]   ram_rd_data
);

    state_t                  state_reg, state_next;
    node_t                   root_reg, root_next;
    logic [NODE_CNT_W-1:0]   nodes_used_reg, nodes_used_next;
    logic [COUNT_W-1:0]      left_reg, left_next;
    logic                    walk_root_reg, walk_root_next;
    node_t                   walk_data_reg, walk_data_next;
    logic [NODE_W-1:0]       cur_idx_reg, cur_idx_next;
    node_t                   cur_data_reg, cur_data_next;
    logic [CODE_LEN_W-1:0]   rem_reg, rem_next;
    logic [CODE_BITS_W-1:0]  bits_reg, bits_next;
    logic [SYM_W-1:0]        sym_reg, sym_next;

    logic                    accept;
    node_t                   walk_node;
    logic [NODE_W-1:0]       bit_kid;
    logic                    len_ok;
    logic [CODE_POS_W-1:0]   load_pos;
    logic                    load_bit;
    logic [NODE_W-1:0]       step_kid;
    logic                    tree_full;
    logic [NODE_W-1:0]       new_idx;
    node_t                   rd_node;
    logic                    wn_en;
    logic [NODE_W-1:0]       wn_idx;
    node_t                   wn_data;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    // The walk position is cached; at the root the live root register is used.
    assign walk_node = walk_root_reg ? root_reg : walk_data_reg;
    assign bit_kid   = walk_node.kid[bit_req];
    assign len_ok    = (code_len != '0) && (code_len <= CODE_LEN_W'(MAX_CODE_LEN));
    assign load_pos  = CODE_POS_W'(rem_reg - CODE_LEN_W'(1));
    assign load_bit  = bits_reg[load_pos];
    assign step_kid  = cur_data_reg.kid[load_bit];
    assign tree_full = (nodes_used_reg >= NODE_CNT_W'(MAX_NODES));
    assign new_idx   = nodes_used_reg[NODE_W-1:0];
    assign rd_node   = node_t'(ram_rd_data);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_BIT && left_reg != '0 && bit_kid != '0)
                    begin
                        state_next = ST_BIT_WAIT;
                    end
                    else if (req_type == REQ_LOAD && len_ok)
                    begin
                        state_next = ST_LOAD_STEP;
                    end
                end
            end
            ST_BIT_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD_STEP:
            begin
                priority if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (step_kid != '0)
                begin
                    state_next = ST_LOAD_READ;
                end
                else if (tree_full)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LOAD_STEP;
                end
            end
            ST_LOAD_READ:
            begin
                state_next = ST_LOAD_STEP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        root_next       = root_reg;
        nodes_used_next = nodes_used_reg;
        left_next       = left_reg;
        walk_root_next  = walk_root_reg;
        walk_data_next  = walk_data_reg;
        cur_idx_next    = cur_idx_reg;
        cur_data_next   = cur_data_reg;
        rem_next        = rem_reg;
        bits_next       = bits_reg;
        sym_next        = sym_reg;
        res             = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        wn_en           = 1'b0;
        wn_idx          = cur_idx_reg;
        wn_data         = cur_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_START:
                        begin
                            root_next       = '0;
                            nodes_used_next = NODE_CNT_W'(1);
                            walk_root_next  = 1'b1;
                            left_next       = symbol_count;
                            res.valid       = 1'b1;
                            res.status      = STAT_OK;
                            res.done        = (symbol_count == '0);
                        end
                        REQ_LOAD:
                        begin
                            walk_root_next = 1'b1;
                            if (!len_ok)
                            begin
                                res.valid  = 1'b1;
                                res.status = STAT_IGNORED;
                                res.done   = (left_reg == '0);
                            end
                            else
                            begin
                                cur_idx_next  = '0;
                                cur_data_next = root_reg;
                                rem_next      = code_len;
                                bits_next     = code_bits;
                                sym_next      = symbol;
                            end
                        end
                        REQ_BIT:
                        begin
                            if (left_reg == '0)
                            begin
                                res.valid  = 1'b1;
                                res.status = STAT_IGNORED;
                                res.done   = 1'b1;
                            end
                            else if (bit_kid == '0)
                            begin
                                walk_root_next = 1'b1;
                                res.valid      = 1'b1;
                                res.status     = STAT_MISSING;
                                res.done       = 1'b0;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = bit_kid;
                            end
                        end
                        default:
                        begin
                            res.valid  = 1'b1;
                            res.status = STAT_IGNORED;
                            res.done   = (left_reg == '0);
                        end
                    endcase
                end
            end
            ST_BIT_WAIT:
            begin
                res.valid  = 1'b1;
                res.status = STAT_OK;
                if (rd_node.leaf)
                begin
                    res.symbol_valid = 1'b1;
                    res.out_symbol   = rd_node.sym;
                    walk_root_next   = 1'b1;
                    left_next        = left_reg - COUNT_W'(1);
                    res.done         = (left_reg == COUNT_W'(1));
                end
                else
                begin
                    walk_data_next = rd_node;
                    walk_root_next = 1'b0;
                    res.done       = 1'b0;
                end
            end
            ST_LOAD_STEP:
            begin
                res.done = (left_reg == '0);
                priority if (rem_reg == '0)
                begin
                    wn_en        = 1'b1;
                    wn_data.leaf = 1'b1;
                    wn_data.sym  = sym_reg;
                    res.valid    = 1'b1;
                    res.status   = STAT_OK;
                end
                else if (step_kid != '0)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = step_kid;
                    cur_idx_next = step_kid;
                    rem_next     = rem_reg - CODE_LEN_W'(1);
                end
                else if (tree_full)
                begin
                    // The current node may be fresh and never stored yet.
                    wn_en      = 1'b1;
                    res.valid  = 1'b1;
                    res.status = STAT_FULL;
                end
                else
                begin
                    wn_en                 = 1'b1;
                    wn_data.kid[load_bit] = new_idx;
                    cur_idx_next          = new_idx;
                    cur_data_next         = '0;
                    nodes_used_next       = nodes_used_reg + NODE_CNT_W'(1);
                    rem_next              = rem_reg - CODE_LEN_W'(1);
                end
            end
            ST_LOAD_READ:
            begin
                cur_data_next = rd_node;
            end
            default:
            begin
            end
        endcase

        // The root lives in a register; all other nodes live in the RAM.
        ram_wr_en   = wn_en && (wn_idx != '0);
        ram_wr_addr = wn_idx;
        ram_wr_data = NODE_BITS'(wn_data);
        if (wn_en && wn_idx == '0)
        begin
            root_next = wn_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            nodes_used_reg <= NODE_CNT_W'(1);
            left_reg       <= '0;
            walk_root_reg  <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            nodes_used_reg <= nodes_used_next;
            left_reg       <= left_next;
            walk_root_reg  <= walk_root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_data_reg <= walk_data_next;
        cur_idx_reg   <= cur_idx_next;
        cur_data_reg  <= cur_data_next;
        rem_reg       <= rem_next;
        bits_reg      <= bits_next;
        sym_reg       <= sym_next;
    end

    `ASSERT_IMPL(a_no_root_in_ram, ram_wr_en, ram_wr_addr != '0, "RAM write to the root index")
    `ASSERT_ALWAYS(a_used_nonzero, nodes_used_reg != '0, "node count is zero")
    `ASSERT_IMPL(a_used_cap, tree_full, nodes_used_reg == NODE_CNT_W'(MAX_NODES), "node count too high")
    `ASSERT_IMPL(a_bit_read_issued, state_reg == ST_BIT_WAIT, $past(ram_rd_en), "bit wait without a read")

endmodule
`default_nettype wire

FILE: sv/huffman_tree_decoder_unit.sv
`default_nettype none
// Each item gives one result, strobed high for a single cycle, in the cycle after its work ends.
// Start, ignored items and missing branches: result strobe in the cycle after accept; busy stays low.
// A decoded bit issues one node RAM read at accept; in BIT_WAIT its data selects the next step.
// A code load: LOAD_STEP adds each new node, LOAD_STEP and LOAD_READ read each existing one;
// LOAD_STEP marks the leaf; a full tree ends it early. The receiver cannot stall the result strobe.
// Reset clears the root node, the node count, the walk and the symbol count; RAM needs no clearing.
module huffman_tree_decoder_unit
    import htd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             req_type,
    input  wire logic [COUNT_W-1:0]     symbol_count,
    input  wire logic [SYM_W-1:0]       symbol,
    input  wire logic [CODE_LEN_W-1:0]  code_len,
    input  wire logic [CODE_BITS_W-1:0] code_bits,
    input  wire logic                   bit_req,
    output logic                        strobe,
    output logic                        symbol_valid,
    output logic [SYM_W-1:0]            out_symbol,
    output logic [1:0]                  status,
    output logic                        done_res
);

    res_t                 res;
    logic                 ram_wr_en;
    logic [NODE_W-1:0]    ram_wr_addr;
    logic [NODE_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [NODE_W-1:0]    ram_rd_addr;
    logic [NODE_BITS-1:0] ram_rd_data;

    logic                 strobe_reg;
    logic                 symbol_valid_reg;
    logic [SYM_W-1:0]     out_symbol_reg;
    logic [1:0]           status_reg;
    logic                 done_res_reg;

    htd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .symbol_count (symbol_count),
        .symbol       (symbol),
        .code_len     (code_len),
        .code_bits    (code_bits),
        .bit_req      (bit_req),
        .busy         (busy),
        .res          (res),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    htd_node_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            symbol_valid_reg <= res.symbol_valid;
            out_symbol_reg   <= res.out_symbol;
            status_reg       <= res.status;
            done_res_reg     <= res.done;
        end
    end

    assign strobe       = strobe_reg;
    assign symbol_valid = symbol_valid_reg;
    assign out_symbol   = out_symbol_reg;
    assign status       = status_reg;
    assign done_res     = done_res_reg;

endmodule
`default_nettype wire

FILE: tb/htd_checker.sv
`timescale 1ns / 100ps
module htd_checker
    import htd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   busy,
    input  wire logic [1:0]             req_type,
    input  wire logic [COUNT_W-1:0]     symbol_count,
    input  wire logic [SYM_W-1:0]       symbol,
    input  wire logic [CODE_LEN_W-1:0]  code_len,
    input  wire logic [CODE_BITS_W-1:0] code_bits,
    input  wire logic                   bit_req,
    input  wire logic                   strobe,
    input  wire logic                   symbol_valid,
    input  wire logic [SYM_W-1:0]       out_symbol,
    input  wire logic [1:0]             status,
    input  wire logic                   done_res,
    output int                          errors,
    output int                          outstanding,
    output int                          symbols_decoded,
    output int                          full_hits
);

    typedef struct packed {
        logic             sym_valid;
        logic [SYM_W-1:0] sym;
        logic [1:0]       stat;
        logic             finished;
    } decode_t;

    // Private copy of the code tree and the decode walk.
    logic               tree_leaf [MAX_NODES];
    logic [SYM_W-1:0]   tree_sym  [MAX_NODES];
    logic [NODE_W-1:0]  tree_kid  [MAX_NODES][2];
    int                 nodes_taken = 1;
    logic [NODE_W-1:0]  walk_at = '0;
    logic [COUNT_W-1:0] symbols_left = '0;
    decode_t            awaited [$];

    function automatic void clear_node(input int n);
        tree_leaf[n]   = 1'b0;
        tree_sym[n]    = '0;
        tree_kid[n][0] = '0;
        tree_kid[n][1] = '0;
    endfunction

    function automatic logic [1:0] insert_code(input logic [SYM_W-1:0] sym,
                                               input logic [CODE_LEN_W-1:0] len,
                                               input logic [CODE_BITS_W-1:0] bits);
        int   cur;
        int   nxt;
        logic b;
        cur = 0;
        // Every load sends the walk back to the root, even an ignored one.
        walk_at = '0;
        if (len == 0 || len > MAX_CODE_LEN)
            return STAT_IGNORED;
        for (int pos = int'(len) - 1; pos >= 0; pos--)
        begin
            b = bits[pos];
            nxt = int'(tree_kid[cur][b]);
            if (nxt == 0)
            begin
                if (nodes_taken >= MAX_NODES)
                    return STAT_FULL;
                nxt = nodes_taken;
                nodes_taken++;
                clear_node(nxt);
                tree_kid[cur][b] = nxt[NODE_W-1:0];
            end
            cur = nxt;
        end
        tree_leaf[cur] = 1'b1;
        tree_sym[cur]  = sym;
        return STAT_OK;
    endfunction

    function automatic decode_t predict_result(input logic [1:0] kind,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic [SYM_W-1:0] sym,
                                               input logic [CODE_LEN_W-1:0] len,
                                               input logic [CODE_BITS_W-1:0] bits,
                                               input logic b);
        decode_t           r;
        logic [NODE_W-1:0] nxt;
        r = '0;
        r.stat = STAT_OK;
        case (kind)
            REQ_START:
            begin
                clear_node(0);
                nodes_taken  = 1;
                walk_at      = '0;
                symbols_left = cnt;
            end
            REQ_LOAD:
                r.stat = insert_code(sym, len, bits);
            REQ_BIT:
            begin
                if (symbols_left == 0)
                    r.stat = STAT_IGNORED;
                else
                begin
                    nxt = tree_kid[walk_at][b];
                    if (nxt == 0)
                    begin
                        walk_at = '0;
                        r.stat  = STAT_MISSING;
                    end
                    else if (tree_leaf[nxt])
                    begin
                        r.sym_valid = 1'b1;
                        r.sym       = tree_sym[nxt];
                        walk_at     = '0;
                        symbols_left--;
                    end
                    else
                        walk_at = nxt;
                end
            end
            default:
                r.stat = STAT_IGNORED;
        endcase
        r.finished = (symbols_left == 0);
        return r;
    endfunction

    task automatic note_failure(input string what, input decode_t want, input decode_t got);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch (%s): expected valid=%b sym=%h status=%0d done=%b,",
                     $realtime, what, want.sym_valid, want.sym, want.stat, want.finished,
                     " got valid=%b sym=%h status=%0d done=%b",
                     got.sym_valid, got.sym, got.stat, got.finished);
    endtask

    always @(posedge clk)
    begin : watch
        decode_t want;
        decode_t got;
        if (!rst_n)
        begin
            clear_node(0);
            nodes_taken  = 1;
            walk_at      = '0;
            symbols_left = '0;
            awaited.delete();
        end
        else
        begin
            // A result seen at this edge belongs to an item accepted earlier.
            if (strobe)
            begin
                got = {symbol_valid, out_symbol, status, done_res};
                if (got.sym_valid === 1'b1)
                    symbols_decoded++;
                if (got.stat === STAT_FULL)
                    full_hits++;
                if (awaited.size() == 0)
                    note_failure("result with no item pending", 'x, got);
                else
                begin
                    want = awaited.pop_front();
                    if (got.sym_valid !== want.sym_valid || got.sym !== want.sym ||
                        got.stat !== want.stat || got.finished !== want.finished)
                        note_failure("field differs", want, got);
                end
            end
            if (start && !busy)
                awaited.push_back(predict_result(req_type, symbol_count, symbol,
                                                 code_len, code_bits, bit_req));
        end
        outstanding = awaited.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import htd_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 560;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [1:0]             req_type = REQ_START;
    logic [COUNT_W-1:0]     symbol_count = '0;
    logic [SYM_W-1:0]       symbol = '0;
    logic [CODE_LEN_W-1:0]  code_len = '0;
    logic [CODE_BITS_W-1:0] code_bits = '0;
    logic                   bit_req = 1'b0;

    wire                    busy;
    wire                    strobe;
    wire                    symbol_valid;
    wire [SYM_W-1:0]        out_symbol;
    wire [1:0]              status;
    wire                    done_res;

    int errors;
    int outstanding;
    int symbols_decoded;
    int full_hits;
    int cycles = 0;
    int items_sent = 0;
    int noise_sent = 0;
    int sent_by_type [4] = '{0, 0, 0, 0};
    int streams = 0;

    always #1 clk = ~clk;

    huffman_tree_decoder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .symbol_count (symbol_count),
        .symbol       (symbol),
        .code_len     (code_len),
        .code_bits    (code_bits),
        .bit_req      (bit_req),
        .strobe       (strobe),
        .symbol_valid (symbol_valid),
        .out_symbol   (out_symbol),
        .status       (status),
        .done_res     (done_res)
    );

    htd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .symbol_count    (symbol_count),
        .symbol          (symbol),
        .code_len        (code_len),
        .code_bits       (code_bits),
        .bit_req         (bit_req),
        .strobe          (strobe),
        .symbol_valid    (symbol_valid),
        .out_symbol      (out_symbol),
        .status          (status),
        .done_res        (done_res),
        .errors          (errors),
        .outstanding     (outstanding),
        .symbols_decoded (symbols_decoded),
        .full_hits       (full_hits)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drops start for one cycle and scrambles the idle payload.
    task automatic idle_cycle();
        @(negedge clk);
        start        <= 1'b0;
        req_type     <= 2'($urandom_range(3));
        symbol_count <= $urandom;
        symbol       <= SYM_W'($urandom);
        code_len     <= CODE_LEN_W'($urandom_range(63));
        code_bits    <= $urandom;
        bit_req      <= 1'($urandom_range(1));
    endtask

    task automatic drain();
        idle_cycle();
        while (outstanding != 0)
            idle_cycle();
    endtask

    task automatic issue(input logic [1:0] kind, input logic [COUNT_W-1:0] cnt,
                         input logic [SYM_W-1:0] sym, input logic [CODE_LEN_W-1:0] len,
                         input logic [CODE_BITS_W-1:0] bits, input logic b);
        if (items_sent < CALM_FROM || items_sent >= CALM_TO)
            while ($urandom_range(99) < 38)
                idle_cycle();
        @(negedge clk);
        start        <= 1'b1;
        req_type     <= kind;
        symbol_count <= cnt;
        symbol       <= sym;
        code_len     <= len;
        code_bits    <= bits;
        bit_req      <= b;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        sent_by_type[kind]++;
    endtask

    task automatic send_start(input logic [COUNT_W-1:0] cnt);
        issue(REQ_START, cnt, SYM_W'($urandom), CODE_LEN_W'($urandom_range(63)), $urandom,
              1'($urandom_range(1)));
    endtask

    task automatic send_load(input logic [SYM_W-1:0] sym, input logic [CODE_LEN_W-1:0] len,
                             input logic [CODE_BITS_W-1:0] bits);
        issue(REQ_LOAD, $urandom, sym, len, bits, 1'($urandom_range(1)));
    endtask

    task automatic send_bit(input logic b);
        issue(REQ_BIT, $urandom, SYM_W'($urandom), CODE_LEN_W'($urandom_range(63)), $urandom, b);
    endtask

    // An unknown request, a load of illegal length or a stray bit.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(2);
        noise_sent++;
        if (pick == 0)
            issue(REQ_UNKNOWN, $urandom, SYM_W'($urandom), CODE_LEN_W'($urandom_range(63)),
                  $urandom, 1'($urandom_range(1)));
        else if (pick == 1)
            send_load(SYM_W'($urandom),
                      CODE_LEN_W'(($urandom_range(1) == 1) ? 0 : $urandom_range(33, 63)),
                      $urandom);
        else
            send_bit(1'($urandom_range(1)));
    endtask

    // Long unrelated codes until the node store runs out, then a few stray bits.
    task automatic fill_tree_stream();
        send_start($urandom_range(1, 8));
        repeat (45)
            send_load(SYM_W'($urandom), CODE_LEN_W'($urandom_range(20, 32)), $urandom);
        repeat (10)
            send_bit(1'($urandom_range(1)));
    endtask

    // A prefix code built by random leaf splits, loaded and then used for a message.
    task automatic coded_stream(input bit broken);
        logic [CODE_BITS_W-1:0] cbits [$];
        int                     clen [$];
        logic [SYM_W-1:0]       csym [$];
        int                     order [$];
        logic [CODE_BITS_W-1:0] w;
        logic [COUNT_W-1:0]     cnt;
        int                     nsyms;
        int                     msg_len;
        int                     idx;
        int                     tries;
        int                     tmp;
        int                     k;
        logic                   b;
        nsyms = $urandom_range(2, ($urandom_range(3) == 0) ? 48 : 12);
        cbits.push_back('0);
        clen.push_back(0);
        tries = 0;
        while (clen.size() < nsyms && tries < 500)
        begin
            tries++;
            // Splitting the newest leaf often gives long chains and deep codes.
            idx = ($urandom_range(1) == 1) ? clen.size() - 1 : $urandom_range(clen.size() - 1);
            if (clen[idx] < MAX_CODE_LEN)
            begin
                w = cbits[idx];
                cbits[idx] = w << 1;
                clen[idx]  = clen[idx] + 1;
                cbits.push_back((w << 1) | 1);
                clen.push_back(clen[idx]);
            end
        end
        foreach (clen[i])
        begin
            csym.push_back(SYM_W'($urandom));
            order.push_back(i);
        end
        for (int i = order.size() - 1; i > 0; i--)
        begin
            idx = $urandom_range(i);
            tmp = order[i];
            order[i] = order[idx];
            order[idx] = tmp;
        end

        msg_len = $urandom_range(1, 20);
        cnt = ($urandom_range(15) == 0) ? $urandom : COUNT_W'(msg_len);
        send_start(cnt);
        foreach (order[i])
        begin
            k = order[i];
            if (broken && $urandom_range(9) == 0)
                continue;
            if ($urandom_range(19) == 0)
                send_noise();
            // Bits above the code length are don't-care, so fill them randomly.
            w = ($urandom << clen[k]) | cbits[k];
            if (clen[k] == 32)
                w = cbits[k];
            send_load(csym[k], CODE_LEN_W'(clen[k]), w);
        end
        repeat (msg_len)
        begin
            k = $urandom_range(clen.size() - 1);
            for (int pos = clen[k] - 1; pos >= 0; pos--)
            begin
                b = cbits[k][pos];
                if (broken && $urandom_range(29) == 0)
                    b = ~b;
                if ($urandom_range(49) == 0)
                    send_noise();
                send_bit(b);
            end
        end
        if (broken)
            repeat ($urandom_range(1, 4))
                send_bit(1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty count, illegal requests, extreme codes and overlaps.
        send_bit(1'b1);
        issue(REQ_UNKNOWN, '1, '1, '1, '1, 1'b1);
        send_start('0);
        send_bit(1'b0);
        send_start('1);
        send_start(COUNT_W'(3));
        send_load(8'h41, 6'd0, '1);
        send_load(8'h42, 6'd33, '0);
        send_load(8'h43, 6'd63, '1);
        send_load(8'h00, 6'd32, 32'hFFFF_FFFF);
        send_load(8'hFF, 6'd2, 32'hFFFF_FFFE);
        send_load(8'h41, 6'd1, 32'h0000_0000);
        // Ends on an inner node of the long all-ones code.
        send_load(8'h80, 6'd2, 32'h0000_0003);
        // Passes through the existing leaf for "10".
        send_load(8'h7E, 6'd3, 32'h0000_0004);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b0);
        send_start(COUNT_W'(2));
        send_load(8'h5A, 6'd1, 32'h8000_0000);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b0);
        drain();

        while (items_sent - noise_sent < RANDOM_ITEMS + 25)
        begin
            streams++;
            if (streams == 1 || $urandom_range(99) < 10)
                fill_tree_stream();
            else
                coded_stream($urandom_range(99) < 25);
            if ($urandom_range(3) == 0)
                drain();
        end

        drain();
        repeat (20)
            idle_cycle();

        $display("Sent %0d items in %0d streams: %0d starts, %0d loads, %0d bits, %0d unknown.",
                 items_sent, streams, sent_by_type[REQ_START], sent_by_type[REQ_LOAD],
                 sent_by_type[REQ_BIT], sent_by_type[REQ_UNKNOWN]);
        $display("Decoded %0d symbols, saw the tree fill up %0d times, %0d mismatches.",
                 symbols_decoded, full_hits, errors);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
